FILE: sv/serial_mouse_report_latch_macros.svh
// assertion macros shared by the mouse report latch modules
// no dependencies; included inside module bodies
`ifndef SERIAL_MOUSE_REPORT_LATCH_MACROS_SVH
`define SERIAL_MOUSE_REPORT_LATCH_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SMRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/smrl_pkg.sv
// shared types and constants for the serial mouse report latch
// no dependencies
package smrl_pkg;

    localparam int DELTA_W     = 16;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;

    localparam logic [3:0] SIGNATURE = 4'b0001;
    localparam logic [6:0] MAG_MAX   = 7'd127;

    typedef enum logic [1:0] {
        OP_PORT_WRITE = 2'd0,
        OP_PORT_READ  = 2'd1,
        OP_BUTTON     = 2'd2,
        OP_MOTION     = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                    opcode;
        logic                       strobe_bit;
        logic                       button_select;
        logic                       button_pressed;
        logic signed [DELTA_W-1:0]  delta_x;
        logic signed [DELTA_W-1:0]  delta_y;
    } t_item;

    typedef struct packed {
        logic valid;
        logic read_bit;
    } t_result;

endpackage

FILE: sv/serial_mouse_report_latch.sv
// Serial game-port mouse report latch.
// Slave stream: one beat per bus event. tuser carries the opcode (port write,
// port read, button change, motion update); tdata carries the strobe bit,
// button select, button pressed and the two signed 16-bit motion deltas.
// Master stream: one beat per port read, read bit in tdata bit 0; other
// events produce no beat.
// A beat lands in an input register. From there the core applies its effect to the
// mouse state and, for a port read, loads the read bit into the result register
// at the same edge; the result register drives master valid.
// Throughput is one beat per cycle. When the master side stalls, a read that
// reaches the core waits in the input register and holds up every beat behind
// it; beats ahead of it still pass. Back-pressure reaches the slave side only
// once a read is held up.
// Reset clears the accumulators, buttons, strobe, sensitivity, report shifter
// and the mode bit; the mode bit is written through i_cfg_wr_en / i_cfg_wr_data
// and keeps only the low report byte when set.
// depends on smrl_pkg, smrl_in_reg, smrl_core, smrl_out_reg
module serial_mouse_report_latch #(
    parameter int ACCUM_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [0] strobe_bit, [1] button_select, [2] button_pressed,
    // [18:3] delta_x, [34:19] delta_y, [39:35] zero
    input  logic [smrl_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [smrl_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] read_bit, [7:1] zero
    output logic [smrl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import smrl_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    take;
    logic    out_ready;
    t_result res;

    smrl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    smrl_core #(
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (item_valid),
        .i_item        (item),
        .i_out_ready   (out_ready),
        .o_take        (take),
        .o_res         (res)
    );

    smrl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (res),
        .o_ready  (out_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

FILE: sv/smrl_in_reg.sv
// input register: captures one beat and unpacks it into an item
// depends on smrl_pkg
module smrl_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [smrl_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [smrl_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic                          i_take,
    output logic                          o_valid,
    output smrl_pkg::t_item               o_item
);
    import smrl_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.opcode         = t_opcode'(i_tuser[1:0]);
        n_item.strobe_bit     = i_tdata[0];
        n_item.button_select  = i_tdata[1];
        n_item.button_pressed = i_tdata[2];
        n_item.delta_x        = i_tdata[18:3];
        n_item.delta_y        = i_tdata[34:19];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: sv/smrl_core.sv
// mouse state: accumulators, buttons, strobe, sensitivity and report shifter
// depends on smrl_pkg and serial_mouse_report_latch_macros.svh
module smrl_core #(
    parameter int ACCUM_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_valid,
    input  smrl_pkg::t_item   i_item,
    input  logic              i_out_ready,
    output logic              o_take,
    output smrl_pkg::t_result o_res
);
    import smrl_pkg::*;
    `include "serial_mouse_report_latch_macros.svh"

    localparam int AW = ACCUM_WIDTH;
    localparam int SW = ((AW > DELTA_W) ? AW : DELTA_W) + 1;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};

    logic                 r_mode;
    logic                 r_strobe;
    logic [31:0]          r_report;
    logic [1:0]           r_sens;
    logic [1:0]           r_btn;
    logic signed [AW-1:0] r_acc_x;
    logic signed [AW-1:0] r_acc_y;

    logic                 n_strobe;
    logic [31:0]          n_report;
    logic [1:0]           n_sens;
    logic [1:0]           n_btn;
    logic signed [AW-1:0] n_acc_x;
    logic signed [AW-1:0] n_acc_y;

    logic                 latch;
    logic [7:0]           enc_x;
    logic [7:0]           enc_y;
    logic [31:0]          report;

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0]      a,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] c;
        s = SW'(a) + SW'(d);
        if (s > SAT_HI) begin
            c = SAT_HI;
        end else if (s < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = s;
        end
        return c[AW-1:0];
    endfunction

    // sign-magnitude, clamped to 127, scaled down by sensitivity
    function automatic logic [7:0] encode_axis(
        input logic signed [AW-1:0] v,
        input logic [1:0]           sens
    );
        logic          neg;
        logic [AW:0]   ext;
        logic [AW:0]   mag;
        logic [6:0]    m7;
        logic [1:0]    sh;
        neg = v[AW-1];
        ext = {v[AW-1], v};
        mag = neg ? (~ext + 1'b1) : ext;
        m7  = (mag > (AW+1)'(MAG_MAX)) ? MAG_MAX : mag[6:0];
        case (sens)
            2'd0:    sh = 2'd2;
            2'd1:    sh = 2'd1;
            default: sh = 2'd0;
        endcase
        return {neg, m7 >> sh};
    endfunction

    assign o_take = i_valid && ((i_item.opcode != OP_PORT_READ) || i_out_ready);

    assign enc_x  = encode_axis(r_acc_x, r_sens);
    assign enc_y  = encode_axis(r_acc_y, r_sens);
    assign report = r_mode ? {24'd0, enc_x}
                           : {8'd0, r_btn[1], r_btn[0], r_sens, SIGNATURE, enc_y, enc_x};
    assign latch  = o_take && (i_item.opcode == OP_PORT_WRITE) && r_strobe
                    && !i_item.strobe_bit;

    always_comb begin
        n_strobe     = r_strobe;
        n_report     = r_report;
        n_sens       = r_sens;
        n_btn        = r_btn;
        n_acc_x      = r_acc_x;
        n_acc_y      = r_acc_y;
        o_res.valid    = 1'b0;
        o_res.read_bit = 1'b0;
        if (o_take) begin
            case (i_item.opcode)
                OP_PORT_WRITE: begin
                    if (!r_strobe && i_item.strobe_bit) begin
                        n_strobe = 1'b1;
                    end else if (latch) begin
                        n_strobe = 1'b0;
                        n_report = report;
                        n_acc_x  = '0;
                        n_acc_y  = '0;
                    end
                end
                OP_PORT_READ: begin
                    o_res.valid = 1'b1;
                    if (r_strobe) begin
                        // strobed read cycles the sensitivity setting
                        case (r_sens)
                            2'd0:    n_sens = 2'd1;
                            2'd1:    n_sens = 2'd2;
                            2'd2:    n_sens = 2'd0;
                            default: n_sens = 2'd1;
                        endcase
                    end else begin
                        o_res.read_bit = r_report[31];
                        n_report       = {r_report[30:0], 1'b0};
                    end
                end
                OP_BUTTON: begin
                    n_btn[i_item.button_select] = i_item.button_pressed;
                end
                default: begin
                    n_acc_x = sat_add(r_acc_x, i_item.delta_x);
                    n_acc_y = sat_add(r_acc_y, i_item.delta_y);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_strobe <= 1'b0;
            r_report <= '0;
            r_sens   <= '0;
            r_btn    <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_strobe <= n_strobe;
            r_report <= n_report;
            r_sens   <= n_sens;
            r_btn    <= n_btn;
            r_acc_x  <= n_acc_x;
            r_acc_y  <= n_acc_y;
        end
    end

    `SMRL_ASSERT_IMP(a_sens_range, i_clk, i_rst_n, 1'b1, r_sens != 2'd3,
        "sensitivity reached an unused code")
    `SMRL_ASSERT_NXT(a_latch_clears, i_clk, i_rst_n, latch,
        !r_strobe && (r_acc_x == '0) && (r_acc_y == '0),
        "report latch did not clear strobe and accumulators")
    `SMRL_ASSERT_NXT(a_strobed_read_holds, i_clk, i_rst_n,
        o_take && (i_item.opcode == OP_PORT_READ) && r_strobe,
        $stable(r_report) && r_strobe,
        "read during strobe disturbed the report shifter")
    `SMRL_ASSERT_IMP(a_stall_only_read, i_clk, i_rst_n, i_valid && !o_take,
        (i_item.opcode == OP_PORT_READ) && !i_out_ready,
        "item held back without a blocked read")

endmodule

FILE: sv/smrl_out_reg.sv
// result register on the master side, one read bit per beat
// depends on smrl_pkg
module smrl_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smrl_pkg::t_result              i_res,
    output logic                           o_ready,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [smrl_pkg::M_TDATA_W-1:0] o_tdata
);
    import smrl_pkg::*;

    logic r_valid;
    logic r_bit;

    assign o_ready  = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = {{(M_TDATA_W-1){1'b0}}, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res.valid) begin
            r_bit <= i_res.read_bit;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for serial_mouse_report_latch: directed and random bus events,
// a cycle-free predictor of the mouse state, and per-beat checking of read bits
// depends on smrl_pkg and the serial_mouse_report_latch rtl
module testbench;
    import smrl_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int ACC_W        = 16;
    localparam int PHASE_ITEMS  = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;
    localparam int MAX_REPORTS  = 10;

    // mouse state tracker: predicts the read bit of every port read
    class mouse_report_tracker;
        bit                       low_byte_mode;
        bit                       strobe_hi;
        bit [31:0]                report;
        bit [1:0]                 sens;
        bit [1:0]                 buttons;
        logic signed [ACC_W-1:0]  acc_x;
        logic signed [ACC_W-1:0]  acc_y;
        bit                       read_bits_due[$];
        int                       errors;

        function new();
            low_byte_mode = 1'b0;
            strobe_hi     = 1'b0;
            report        = '0;
            sens          = '0;
            buttons       = '0;
            acc_x         = '0;
            acc_y         = '0;
            errors        = 0;
        endfunction

        function logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                  logic signed [DELTA_W-1:0] d);
            longint s;
            longint hi;
            hi = (longint'(1) <<< (ACC_W - 1)) - 1;
            s  = longint'(a) + longint'(d);
            if (s > hi)
                s = hi;
            if (s < -hi - 1)
                s = -hi - 1;
            return ACC_W'(s);
        endfunction

        // sign-magnitude, magnitude clamped then scaled by sensitivity
        function bit [7:0] encode_axis(logic signed [ACC_W-1:0] v, bit [1:0] s);
            longint m;
            int     sh;
            bit     neg;
            m   = longint'(v);
            neg = 1'b0;
            if (m < 0) begin
                neg = 1'b1;
                m   = -m;
            end
            if (m > 127)
                m = 127;
            sh = (s > 2) ? 0 : 2 - s;
            return {neg, 7'(m >> sh)};
        endfunction

        function void note_beat(t_item it);
            bit [31:0] r;
            case (it.opcode)
                OP_PORT_WRITE: begin
                    if (!strobe_hi && it.strobe_bit) begin
                        strobe_hi = 1'b1;
                    end else if (strobe_hi && !it.strobe_bit) begin
                        r = {8'h00, buttons[1], buttons[0], sens, SIGNATURE,
                             encode_axis(acc_y, sens), encode_axis(acc_x, sens)};
                        if (low_byte_mode)
                            r = r & 32'h0000_00ff;
                        report    = r;
                        strobe_hi = 1'b0;
                        acc_x     = '0;
                        acc_y     = '0;
                    end
                end
                OP_PORT_READ: begin
                    if (strobe_hi) begin
                        sens = 2'((int'(sens) + 1) % 3);
                        read_bits_due.push_back(1'b0);
                    end else begin
                        read_bits_due.push_back(report[31]);
                        report = report << 1;
                    end
                end
                OP_BUTTON: begin
                    buttons[it.button_select] = it.button_pressed;
                end
                default: begin
                    acc_x = sat_add(acc_x, it.delta_x);
                    acc_y = sat_add(acc_y, it.delta_y);
                end
            endcase
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_read_bit(logic [M_TDATA_W-1:0] data);
            bit exp_bit;
            if (read_bits_due.size() == 0) begin
                log_error($sformatf("read beat with nothing pending, tdata %h", data));
                return;
            end
            exp_bit = read_bits_due.pop_front();
            if (data !== {{(M_TDATA_W-1){1'b0}}, exp_bit})
                log_error($sformatf("read bit mismatch: expected tdata %h, got %h",
                                    {{(M_TDATA_W-1){1'b0}}, exp_bit}, data));
        endfunction

        function int pending();
            return read_bits_due.size();
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_wr_en    = 1'b0;
    logic                   i_cfg_wr_data  = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    mouse_report_tracker    tracker = new();
    int                     src_idle_pct  = 0;
    int                     sink_idle_pct = 0;
    int                     n_sent        = 0;
    int                     quiet_cycles  = 0;
    int                     hold_left     = 0;
    bit                     hold_req      = 1'b0;

    serial_mouse_report_latch u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // read side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_read_bit(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // returns at the rising edge where the beat is taken
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.opcode;
        s_axis_tdata  <= {{(S_TDATA_W-35){1'b0}}, it.delta_y, it.delta_x,
                          it.button_pressed, it.button_select, it.strobe_bit};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tracker.note_beat(it);
        n_sent++;
    endtask

    function automatic t_item random_item(t_opcode op);
        logic [63:0] r;
        t_item       it;
        r         = {$urandom, $urandom};
        it        = r[$bits(t_item)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic logic signed [DELTA_W-1:0] rand_delta();
        case ($urandom_range(9))
            0:       return DELTA_W'($urandom);
            1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return DELTA_W'($urandom_range(80)) - 16'sd40;
        endcase
    endfunction

    task automatic send_write(input bit strobe);
        t_item it;
        it            = random_item(OP_PORT_WRITE);
        it.strobe_bit = strobe;
        send_item(it);
    endtask

    task automatic send_read();
        send_item(random_item(OP_PORT_READ));
    endtask

    task automatic send_button(input bit sel, input bit pressed);
        t_item it;
        it                = random_item(OP_BUTTON);
        it.button_select  = sel;
        it.button_pressed = pressed;
        send_item(it);
    endtask

    task automatic send_motion(input logic signed [DELTA_W-1:0] dx,
                               input logic signed [DELTA_W-1:0] dy);
        t_item it;
        it         = random_item(OP_MOTION);
        it.delta_x = dx;
        it.delta_y = dy;
        send_item(it);
    endtask

    // motion and buttons, strobe, optional sensitivity steps, latch, shift out
    task automatic send_frame();
        int n;
        n = $urandom_range(5);
        repeat (n) send_motion(rand_delta(), rand_delta());
        n = $urandom_range(2);
        repeat (n) send_button(bit'($urandom_range(1)), bit'($urandom_range(1)));
        send_write(1'b1);
        if ($urandom_range(7) == 0)
            send_write(1'b1);
        n = $urandom_range(2);
        repeat (n) send_read();
        send_write(1'b0);
        if ($urandom_range(7) == 0)
            send_write(1'b0);
        n = ($urandom_range(5) == 0) ? $urandom_range(1, 36) : 32;
        repeat (n) begin
            if ($urandom_range(15) == 0)
                send_motion(rand_delta(), rand_delta());
            send_read();
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_item(random_item(t_opcode'($urandom_range(3))));
    endtask

    // leaves the block idle: all read bits back, write beats settled
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input bit mode);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.low_byte_mode = mode;
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input bit mode,
                             input bit with_hold);
        int  first;
        bit  held;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        held          = 1'b0;
        cfg_write(mode);
        first = n_sent;
        while (n_sent - first < PHASE_ITEMS) begin
            if (with_hold && !held && n_sent - first > 50) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(4) == 0)
                send_noise();
            else
                send_frame();
        end
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation both ways, all button moves, no-edge writes,
        // sensitivity stepping through its wrap
        cfg_write(1'b0);
        send_motion(16'sh7fff, 16'sh7fff);
        send_motion(16'sh7fff, 16'sh7fff);
        send_button(1'b0, 1'b1);
        send_button(1'b1, 1'b1);
        send_button(1'b1, 1'b0);
        send_button(1'b1, 1'b1);
        send_write(1'b1);
        send_write(1'b1);
        send_read();
        send_read();
        send_write(1'b0);
        send_write(1'b0);
        repeat (8) send_read();
        send_motion(16'sh8000, 16'sh8000);
        send_motion(-16'sd1, 16'sd0);
        send_button(1'b0, 1'b0);
        send_write(1'b1);
        send_read();
        send_write(1'b0);
        drain();

        run_phase(8, 48, 1'b0, 1'b0);
        run_phase(48, 8, 1'b1, 1'b0);
        run_phase(0, 0, 1'b0, 1'b1);
        run_phase(0, 0, 1'b1, 1'b0);

        if (tracker.pending() != 0)
            tracker.log_error($sformatf("%0d read bits never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/smrl_pkg.sv
sv/smrl_in_reg.sv
sv/smrl_core.sv
sv/smrl_out_reg.sv
sv/serial_mouse_report_latch.sv
tb/testbench.sv
